### rtl/core/modular_coeff_alu_defines.svh
// ----------------------------------------------------------------------------
// Modular coefficient ALU assertion macros
// Shared property templates clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MODULAR_COEFF_ALU_DEFINES_SVH
`define MODULAR_COEFF_ALU_DEFINES_SVH

// Same-cycle implication.
`define MCA_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define MCA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/mca_pkg.sv
// ----------------------------------------------------------------------------
// Modular coefficient ALU package
// Widths, pipeline stage numbers, codes and shared types of the ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package mca_pkg;

   localparam int COEFF_BITS   = 61;
   localparam int WORD_BITS    = 64;
   localparam int HALF_BITS    = WORD_BITS / 2;
   localparam int PROD_BITS    = 2 * WORD_BITS;
   localparam int DATA_BITS    = 64;
   localparam int BYTE_BITS    = 3;
   localparam int REG_IDX_BITS = 3;
   localparam int ADDR_BITS    = REG_IDX_BITS + BYTE_BITS;

   // Pipeline stage numbers.
   localparam int STG_IN    = 0;
   localparam int STG_PROD  = 1;
   localparam int STG_X     = 2;
   localparam int STG_RATIO = 3;
   localparam int STG_ACC   = 4;
   localparam int STG_QHAT  = 5;
   localparam int STG_QPP   = 6;
   localparam int STG_QMOD  = 7;
   localparam int STG_REM   = 8;
   localparam int STG_OUT   = 9;
   localparam int PIPE_STAGES = STG_OUT + 1;

   typedef enum logic [1:0] {
      MODE_ADD     = 2'd0,
      MODE_SUB     = 2'd1,
      MODE_BARRETT = 2'd2,
      MODE_SHOUP   = 2'd3
   } mode_type;

   typedef enum logic [REG_IDX_BITS-1:0] {
      REG_MODULUS         = 3'd0,
      REG_RATIO_LOW       = 3'd1,
      REG_RATIO_HIGH      = 3'd2,
      REG_SCALAR_VALUE    = 3'd3,
      REG_SCALAR_QUOTIENT = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [COEFF_BITS-1:0] modulus;
      logic [WORD_BITS-1:0]  ratio_low;
      logic [WORD_BITS-1:0]  ratio_high;
      logic [COEFF_BITS-1:0] scalar_value;
      logic [WORD_BITS-1:0]  scalar_quotient;
   } cfg_type;

   typedef struct packed {
      logic [PIPE_STAGES-1:0] adv;
      logic [PIPE_STAGES-1:0] valid;
   } pipe_ctrl_type;

   function automatic logic [WORD_BITS-1:0] to_word(input logic [COEFF_BITS-1:0] v);
      return {{(WORD_BITS - COEFF_BITS){1'b0}}, v};
   endfunction

endpackage

`default_nettype wire

### rtl/core/mca_csr.sv
// ----------------------------------------------------------------------------
// Modular coefficient ALU register file
// APB-style access to the modulus, Barrett ratio and Shoup scalar registers.
// ----------------------------------------------------------------------------
`default_nettype none

module mca_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [mca_pkg::ADDR_BITS-1:0]  paddr,
   input  logic [mca_pkg::DATA_BITS-1:0]  pwdata,
   output logic [mca_pkg::DATA_BITS-1:0]  prdata,
   output logic                           pready,
   output mca_pkg::cfg_type               cfg
);
   import mca_pkg::*;

   logic [REG_IDX_BITS-1:0] idx;
   logic                    write_en;
   cfg_type                 cfg_ff;
   cfg_type                 cfg_in;

   assign idx      = paddr[ADDR_BITS-1:BYTE_BITS];
   assign write_en = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (idx)
            REG_MODULUS:         cfg_in.modulus         = pwdata[COEFF_BITS-1:0];
            REG_RATIO_LOW:       cfg_in.ratio_low       = pwdata[WORD_BITS-1:0];
            REG_RATIO_HIGH:      cfg_in.ratio_high      = pwdata[WORD_BITS-1:0];
            REG_SCALAR_VALUE:    cfg_in.scalar_value    = pwdata[COEFF_BITS-1:0];
            REG_SCALAR_QUOTIENT: cfg_in.scalar_quotient = pwdata[WORD_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.modulus         <= COEFF_BITS'(2);
         cfg_ff.ratio_low       <= '0;
         cfg_ff.ratio_high      <= '0;
         cfg_ff.scalar_value    <= '0;
         cfg_ff.scalar_quotient <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (idx)
         REG_MODULUS:         prdata = DATA_BITS'(to_word(cfg_ff.modulus));
         REG_RATIO_LOW:       prdata = DATA_BITS'(cfg_ff.ratio_low);
         REG_RATIO_HIGH:      prdata = DATA_BITS'(cfg_ff.ratio_high);
         REG_SCALAR_VALUE:    prdata = DATA_BITS'(to_word(cfg_ff.scalar_value));
         REG_SCALAR_QUOTIENT: prdata = DATA_BITS'(cfg_ff.scalar_quotient);
         default:             prdata = '0;
      endcase
   end

   assign pready = 1'b1;
   assign cfg    = cfg_ff;

endmodule

`default_nettype wire

### rtl/core/mca_wide_mul.sv
// ----------------------------------------------------------------------------
// Modular coefficient ALU wide multiplier
// Two-stage 64 x 64 to 128-bit product: registered 32 x 32 partial products,
// then a registered sum.
// ----------------------------------------------------------------------------
`default_nettype none

module mca_wide_mul (
   input  logic                          clock,
   input  logic                          load_pp,
   input  logic                          load_sum,
   input  logic [mca_pkg::WORD_BITS-1:0] x,
   input  logic [mca_pkg::WORD_BITS-1:0] y,
   output logic [mca_pkg::PROD_BITS-1:0] prod
);
   import mca_pkg::*;

   logic [HALF_BITS-1:0] x_lo;
   logic [HALF_BITS-1:0] x_hi;
   logic [HALF_BITS-1:0] y_lo;
   logic [HALF_BITS-1:0] y_hi;
   logic [WORD_BITS-1:0] p00_in;
   logic [WORD_BITS-1:0] p01_in;
   logic [WORD_BITS-1:0] p10_in;
   logic [WORD_BITS-1:0] p11_in;
   logic [WORD_BITS-1:0] p00_ff;
   logic [WORD_BITS-1:0] p01_ff;
   logic [WORD_BITS-1:0] p10_ff;
   logic [WORD_BITS-1:0] p11_ff;
   logic [PROD_BITS-1:0] prod_in;
   logic [PROD_BITS-1:0] prod_ff;

   assign x_lo = x[HALF_BITS-1:0];
   assign x_hi = x[WORD_BITS-1:HALF_BITS];
   assign y_lo = y[HALF_BITS-1:0];
   assign y_hi = y[WORD_BITS-1:HALF_BITS];

   assign p00_in = WORD_BITS'(x_lo) * WORD_BITS'(y_lo);
   assign p01_in = WORD_BITS'(x_lo) * WORD_BITS'(y_hi);
   assign p10_in = WORD_BITS'(x_hi) * WORD_BITS'(y_lo);
   assign p11_in = WORD_BITS'(x_hi) * WORD_BITS'(y_hi);

   assign prod_in = PROD_BITS'(p00_ff)
                  + (PROD_BITS'(p01_ff) << HALF_BITS)
                  + (PROD_BITS'(p10_ff) << HALF_BITS)
                  + (PROD_BITS'(p11_ff) << WORD_BITS);

   always_ff @(posedge clock) begin
      if (load_pp) begin
         p00_ff <= p00_in;
         p01_ff <= p01_in;
         p10_ff <= p10_in;
         p11_ff <= p11_in;
      end
      if (load_sum) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

### rtl/core/mca_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// Modular coefficient ALU pipeline control
// Per-stage valid bits and advance enables; a stage moves whenever it is
// empty or the stage after it moves, so bubbles close up under a stall.
// ----------------------------------------------------------------------------
`default_nettype none

module mca_pipe_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic                   out_ready,
   output logic                   in_ready,
   output logic                   out_valid,
   output mca_pkg::pipe_ctrl_type ctrl
);
   import mca_pkg::*;

   logic [PIPE_STAGES-1:0] valid_ff;
   logic [PIPE_STAGES-1:0] valid_in;
   logic [PIPE_STAGES-1:0] adv;

   always_comb begin
      adv[PIPE_STAGES-1] = !valid_ff[PIPE_STAGES-1] || out_ready;
      for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   always_comb begin
      valid_in[0] = adv[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < PIPE_STAGES; k++) begin
         valid_in[k] = adv[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready   = adv[0];
   assign out_valid  = valid_ff[PIPE_STAGES-1];
   assign ctrl.adv   = adv;
   assign ctrl.valid = valid_ff;

endmodule

`default_nettype wire

### rtl/core/modular_coeff_alu.sv
// ----------------------------------------------------------------------------
// Modular coefficient ALU
// Modular add, subtract, Barrett multiply and Shoup scalar multiply on one
// coefficient pair per word. The block is a ten-stage pipeline: a word is
// taken every cycle unless an output stall has filled every stage, and its
// result is held in the last stage's register. The depth is set by the
// three chained 64-bit multiplications of the Barrett path, each built from
// registered 32 x 32 partial products and a registered sum, plus the
// quotient assembly and the final subtract and correction. Stalls at the
// output stop only the stages that are full, so idle stages keep taking
// words. Registers must be written only while no word is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "modular_coeff_alu_defines.svh"

module modular_coeff_alu (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_type,
   input  logic [mca_pkg::COEFF_BITS-1:0] req_operand_a,
   input  logic [mca_pkg::COEFF_BITS-1:0] req_operand_b,
   input  logic                           req_last_in,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [mca_pkg::COEFF_BITS-1:0] rsp_result,
   output logic                           rsp_last_out,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [mca_pkg::ADDR_BITS-1:0]  paddr,
   input  logic [mca_pkg::DATA_BITS-1:0]  pwdata,
   output logic [mca_pkg::DATA_BITS-1:0]  prdata,
   output logic                           pready
);
   import mca_pkg::*;

   typedef struct packed {
      mode_type              mode;
      logic                  last;
      logic [COEFF_BITS-1:0] res;
      logic [WORD_BITS-1:0]  x;
      logic [WORD_BITS-1:0]  hi;
   } stage_type;

   cfg_type       cfg;
   pipe_ctrl_type ctrl;

   stage_type stage_ff [PIPE_STAGES];
   stage_type stage_in [PIPE_STAGES];

   logic [WORD_BITS-1:0] a_w;
   logic [WORD_BITS-1:0] b_w;
   logic [WORD_BITS-1:0] q_w;
   logic [WORD_BITS-1:0] mul_y;
   logic [WORD_BITS-1:0] sum_w;
   logic [WORD_BITS:0]   sum_red;
   logic [WORD_BITS-1:0] add_res;
   logic [WORD_BITS-1:0] diff_w;
   logic [WORD_BITS-1:0] diff_q;
   logic [WORD_BITS-1:0] sub_res;
   logic [WORD_BITS-1:0] simple_res;

   logic [PROD_BITS-1:0] prod_a;
   logic [PROD_BITS-1:0] prod_s;
   logic [PROD_BITS-1:0] prod_ll;
   logic [PROD_BITS-1:0] prod_lh;
   logic [PROD_BITS-1:0] prod_hl;
   logic [PROD_BITS-1:0] prod_hh;
   logic [PROD_BITS-1:0] prod_q;

   logic [WORD_BITS:0]   acc_sum;
   logic [WORD_BITS-1:0] acc_in;
   logic [WORD_BITS-1:0] acc_ff;
   logic [WORD_BITS-1:0] top_in;
   logic [WORD_BITS-1:0] top_ff;
   logic [WORD_BITS-1:0] pl2_ff;
   logic [WORD_BITS-1:0] ph2_ff;
   logic [WORD_BITS-1:0] zhrh_ff;

   logic [WORD_BITS:0]   s_sum;
   logic [WORD_BITS-1:0] qb;
   logic [WORD_BITS-1:0] qhat_in;
   logic [WORD_BITS-1:0] qhat_ff;

   logic [WORD_BITS-1:0] rem_in;
   logic [WORD_BITS-1:0] rem_ff;
   logic [WORD_BITS:0]   rem_red;
   logic [WORD_BITS-1:0] rem_fix;

   mca_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mca_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .out_ready (rsp_ready),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .ctrl      (ctrl)
   );

   assign a_w = to_word(req_operand_a);
   assign b_w = to_word(req_operand_b);
   assign q_w = to_word(cfg.modulus);

   // Add and subtract finish in the input stage and ride along to the output.
   assign sum_w   = a_w + b_w;
   assign sum_red = {1'b0, sum_w} - {1'b0, q_w};
   assign add_res = sum_red[WORD_BITS] ? sum_w : sum_red[WORD_BITS-1:0];
   assign diff_w  = a_w - b_w;
   assign diff_q  = a_w - b_w + q_w;
   assign sub_res = (a_w < b_w) ? diff_q : diff_w;
   assign simple_res = (mode_type'(req_type) == MODE_SUB) ? sub_res : add_res;

   assign mul_y = (mode_type'(req_type) == MODE_SHOUP) ? cfg.scalar_quotient : b_w;

   mca_wide_mul u_mul_a (
      .clock    (clock),
      .load_pp  (ctrl.adv[STG_IN]),
      .load_sum (ctrl.adv[STG_PROD]),
      .x        (a_w),
      .y        (mul_y),
      .prod     (prod_a)
   );

   mca_wide_mul u_mul_s (
      .clock    (clock),
      .load_pp  (ctrl.adv[STG_IN]),
      .load_sum (ctrl.adv[STG_PROD]),
      .x        (a_w),
      .y        (to_word(cfg.scalar_value)),
      .prod     (prod_s)
   );

   mca_wide_mul u_mul_ll (
      .clock    (clock),
      .load_pp  (ctrl.adv[STG_X]),
      .load_sum (ctrl.adv[STG_RATIO]),
      .x        (prod_a[WORD_BITS-1:0]),
      .y        (cfg.ratio_low),
      .prod     (prod_ll)
   );

   mca_wide_mul u_mul_lh (
      .clock    (clock),
      .load_pp  (ctrl.adv[STG_X]),
      .load_sum (ctrl.adv[STG_RATIO]),
      .x        (prod_a[WORD_BITS-1:0]),
      .y        (cfg.ratio_high),
      .prod     (prod_lh)
   );

   mca_wide_mul u_mul_hl (
      .clock    (clock),
      .load_pp  (ctrl.adv[STG_X]),
      .load_sum (ctrl.adv[STG_RATIO]),
      .x        (prod_a[PROD_BITS-1:WORD_BITS]),
      .y        (cfg.ratio_low),
      .prod     (prod_hl)
   );

   mca_wide_mul u_mul_hh (
      .clock    (clock),
      .load_pp  (ctrl.adv[STG_X]),
      .load_sum (ctrl.adv[STG_RATIO]),
      .x        (prod_a[PROD_BITS-1:WORD_BITS]),
      .y        (cfg.ratio_high),
      .prod     (prod_hh)
   );

   // Quotient estimate, first half: low word and carry of the middle column.
   assign acc_sum = {1'b0, prod_lh[WORD_BITS-1:0]} + {1'b0, prod_ll[PROD_BITS-1:WORD_BITS]};
   assign acc_in  = acc_sum[WORD_BITS-1:0];
   assign top_in  = prod_lh[PROD_BITS-1:WORD_BITS] + WORD_BITS'(acc_sum[WORD_BITS]);

   always_ff @(posedge clock) begin
      if (ctrl.adv[STG_ACC]) begin
         acc_ff  <= acc_in;
         top_ff  <= top_in;
         pl2_ff  <= prod_hl[WORD_BITS-1:0];
         ph2_ff  <= prod_hl[PROD_BITS-1:WORD_BITS];
         zhrh_ff <= prod_hh[WORD_BITS-1:0];
      end
   end

   // Quotient estimate, second half; the Shoup path takes the high product word.
   assign s_sum   = {1'b0, acc_ff} + {1'b0, pl2_ff};
   assign qb      = zhrh_ff + top_ff + ph2_ff + WORD_BITS'(s_sum[WORD_BITS]);
   assign qhat_in = (stage_ff[STG_ACC].mode == MODE_SHOUP) ? stage_ff[STG_ACC].hi : qb;

   always_ff @(posedge clock) begin
      if (ctrl.adv[STG_QHAT]) begin
         qhat_ff <= qhat_in;
      end
   end

   mca_wide_mul u_mul_q (
      .clock    (clock),
      .load_pp  (ctrl.adv[STG_QPP]),
      .load_sum (ctrl.adv[STG_QMOD]),
      .x        (qhat_ff),
      .y        (q_w),
      .prod     (prod_q)
   );

   assign rem_in = stage_ff[STG_QMOD].x - prod_q[WORD_BITS-1:0];

   always_ff @(posedge clock) begin
      if (ctrl.adv[STG_REM]) begin
         rem_ff <= rem_in;
      end
   end

   assign rem_red = {1'b0, rem_ff} - {1'b0, q_w};
   assign rem_fix = rem_red[WORD_BITS] ? rem_ff : rem_red[WORD_BITS-1:0];

   always_comb begin
      stage_in[STG_IN].mode = mode_type'(req_type);
      stage_in[STG_IN].last = req_last_in;
      stage_in[STG_IN].res  = simple_res[COEFF_BITS-1:0];
      stage_in[STG_IN].x    = '0;
      stage_in[STG_IN].hi   = '0;
      for (int k = 1; k < PIPE_STAGES; k++) begin
         stage_in[k] = stage_ff[k-1];
      end
      stage_in[STG_X].x = (stage_ff[STG_PROD].mode == MODE_SHOUP) ?
                          prod_s[WORD_BITS-1:0] : prod_a[WORD_BITS-1:0];
      stage_in[STG_X].hi = prod_a[PROD_BITS-1:WORD_BITS];
      if (stage_ff[STG_REM].mode == MODE_BARRETT || stage_ff[STG_REM].mode == MODE_SHOUP) begin
         stage_in[STG_OUT].res = rem_fix[COEFF_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < PIPE_STAGES; k++) begin
         if (ctrl.adv[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign rsp_result   = stage_ff[STG_OUT].res;
   assign rsp_last_out = stage_ff[STG_OUT].last;

   `MCA_ASSERT(full_when_blocked, !ctrl.adv[STG_IN], &ctrl.valid, "input blocked with a free stage")
   `MCA_ASSERT_NEXT(accept_enters, req_valid && req_ready, ctrl.valid[STG_IN], "accepted word lost")
   `MCA_ASSERT(drop_after_take, $fell(rsp_valid), $past(rsp_ready), "result dropped without handshake")

endmodule

`default_nettype wire
